[hw/rtl/string_to_uint64_parser_unit_macros.svh]
// Assertion macros for the checker of the string parser unit.
// Both macros expect a signal named clk in their scope; SU64P_ASSERT also rst.
`ifndef STRING_TO_UINT64_PARSER_UNIT_MACROS_SVH
`define STRING_TO_UINT64_PARSER_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SU64P_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SU64P_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/su64p_pkg.sv]
// Types, constants and character helpers for the string to uint64 parser.
// Used by su64p_step, the top level and the checker.
package su64p_pkg;

  localparam int POS_BITS = 16;
  localparam int OFS_BITS = 16;
  localparam int EXT_BITS = (POS_BITS > OFS_BITS) ? POS_BITS : OFS_BITS;
  localparam int VAL_BITS = 64;
  localparam int BASE_BITS = 6;

  localparam logic [BASE_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_ONE = 6'd1;
  localparam logic [BASE_BITS-1:0] NO_DIGIT = 6'd63;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_BASE = 2'd1;
  localparam logic [1:0] STATUS_BAD_PREFIX = 2'd2;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [OFS_BITS-1:0] OFS_MAX = {OFS_BITS{1'b1}};

  typedef enum logic [7:0] {
    PH_SPACE      = 8'b0000_0001,
    PH_START      = 8'b0000_0010,
    PH_ZERO       = 8'b0000_0100,
    PH_XSEEN      = 8'b0000_1000,
    PH_DIGITS     = 8'b0001_0000,
    PH_DONE       = 8'b0010_0000,
    PH_BADBASE    = 8'b0100_0000,
    PH_BADPREFIX  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic                  neg;
    logic [BASE_BITS-1:0]  base;
    logic [VAL_BITS-1:0]   acc;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   stop;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OFS_BITS-1:0]  end_offset;
    logic [VAL_BITS-1:0]  value;
  } result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase: PH_SPACE, neg: 1'b0, base: BASE_AUTO, acc: '0, pos: '0, stop: '0
  };

  function automatic logic [BASE_BITS-1:0] digit_of(input logic [7:0] c);
    logic [BASE_BITS-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = BASE_BITS'(c - CH_ZERO);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = BASE_BITS'(c - CH_UA) + BASE_DEC;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = BASE_BITS'(c - CH_LA) + BASE_DEC;
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

[hw/rtl/su64p_step.sv]
// Next-state and result logic for one character of the parser.
// Depends on su64p_pkg; purely combinational, one multiply-add per word.
module su64p_step (
  input  su64p_pkg::parse_state_t         cur,
  input  logic [7:0]                      ch,
  input  logic                            last,
  input  logic [su64p_pkg::BASE_BITS-1:0] radix,
  output su64p_pkg::parse_state_t         nxt,
  output su64p_pkg::result_t              res
);

  logic                            first;
  logic [su64p_pkg::BASE_BITS-1:0] base;
  su64p_pkg::phase_t               phase;
  logic [su64p_pkg::BASE_BITS-1:0] digit;
  logic [su64p_pkg::BASE_BITS-1:0] eff_base;
  logic                            do_take;
  logic                            mark;
  logic [su64p_pkg::VAL_BITS-1:0]  mac;
  logic [su64p_pkg::POS_BITS-1:0]  pos_inc;
  logic [su64p_pkg::EXT_BITS-1:0]  stop_ext;
  su64p_pkg::parse_state_t         upd;
  su64p_pkg::phase_t               fin_phase;
  logic [su64p_pkg::VAL_BITS-1:0]  val;

  assign first = (cur.pos == '0) && (cur.phase == su64p_pkg::PH_SPACE);
  assign base  = first ? radix : cur.base;
  assign digit = su64p_pkg::digit_of(ch);
  assign pos_inc = (cur.pos < su64p_pkg::POS_MAX) ? cur.pos + 1'b1 : su64p_pkg::POS_MAX;
  assign mac = cur.acc * su64p_pkg::VAL_BITS'(eff_base) + su64p_pkg::VAL_BITS'(digit);

  always_comb begin
    phase = cur.phase;
    if (first && (radix == su64p_pkg::BASE_ONE || radix > su64p_pkg::BASE_MAX)) begin
      phase = su64p_pkg::PH_BADBASE;
    end
    upd      = cur;
    upd.base = base;
    upd.pos  = pos_inc;
    eff_base = base;
    do_take  = 1'b0;
    mark     = 1'b0;
    case (phase)
      su64p_pkg::PH_SPACE, su64p_pkg::PH_START: begin
        upd.phase = phase;
        if (phase == su64p_pkg::PH_SPACE && su64p_pkg::is_space(ch)) begin
          upd.phase = phase;
        end else if (phase == su64p_pkg::PH_SPACE &&
                     (ch == su64p_pkg::CH_PLUS || ch == su64p_pkg::CH_MINUS)) begin
          upd.neg   = (ch == su64p_pkg::CH_MINUS);
          upd.phase = su64p_pkg::PH_START;
        end else if ((base == su64p_pkg::BASE_AUTO || base == su64p_pkg::BASE_HEX) &&
                     ch == su64p_pkg::CH_ZERO) begin
          mark      = 1'b1;
          upd.phase = su64p_pkg::PH_ZERO;
        end else begin
          do_take  = 1'b1;
          eff_base = (base == su64p_pkg::BASE_AUTO) ? su64p_pkg::BASE_DEC : base;
        end
      end
      su64p_pkg::PH_ZERO: begin
        if (ch == su64p_pkg::CH_LX || ch == su64p_pkg::CH_UX) begin
          upd.phase = su64p_pkg::PH_XSEEN;
        end else begin
          do_take  = 1'b1;
          eff_base = (base == su64p_pkg::BASE_AUTO) ? su64p_pkg::BASE_OCT : base;
        end
      end
      su64p_pkg::PH_XSEEN: begin
        eff_base = su64p_pkg::BASE_HEX;
        upd.base = su64p_pkg::BASE_HEX;
        if (digit < su64p_pkg::BASE_HEX) begin
          do_take = 1'b1;
        end else begin
          upd.phase = su64p_pkg::PH_BADPREFIX;
        end
      end
      su64p_pkg::PH_DIGITS: begin
        do_take = 1'b1;
      end
      default: begin
        upd.phase = phase;
      end
    endcase
    if (do_take) begin
      upd.base = eff_base;
      if (digit < eff_base) begin
        upd.acc   = mac;
        mark      = 1'b1;
        upd.phase = su64p_pkg::PH_DIGITS;
      end else begin
        upd.phase = su64p_pkg::PH_DONE;
      end
    end
    if (mark) begin
      upd.stop = pos_inc;
    end
  end

  always_comb begin
    fin_phase = (upd.phase == su64p_pkg::PH_XSEEN) ? su64p_pkg::PH_BADPREFIX : upd.phase;
    val       = upd.neg ? (~upd.acc + 1'b1) : upd.acc;
    stop_ext  = su64p_pkg::EXT_BITS'(upd.stop);
    res.value  = val;
    res.status = su64p_pkg::STATUS_OK;
    if (stop_ext > su64p_pkg::EXT_BITS'(su64p_pkg::OFS_MAX)) begin
      res.end_offset = su64p_pkg::OFS_MAX;
    end else begin
      res.end_offset = stop_ext[su64p_pkg::OFS_BITS-1:0];
    end
    if (fin_phase == su64p_pkg::PH_BADBASE || fin_phase == su64p_pkg::PH_BADPREFIX) begin
      res.value      = '0;
      res.end_offset = '0;
      res.status     = (fin_phase == su64p_pkg::PH_BADBASE) ?
                       su64p_pkg::STATUS_BAD_BASE : su64p_pkg::STATUS_BAD_PREFIX;
    end
    nxt = last ? su64p_pkg::STATE_CLEAR : upd;
  end

endmodule

[hw/rtl/string_to_uint64_parser_unit.sv]
// String to uint64 parser: one character word in, one result word per string.
// A last character waits in the input register while the result word is stalled.
// Throughput: one character per cycle otherwise; the per-character multiply-add
// by the base between the input register and the parse state sets the cycle.
// Reset (rst, synchronous, active high) clears the parse state, empties both
// registers and sets the radix to 10.
module string_to_uint64_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,   // radix
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // char_in
  input  logic        s_tlast,    // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,    // value [63:0], end_offset [79:64]
  output logic [1:0]  m_tuser     // status
);

  logic [su64p_pkg::BASE_BITS-1:0] radix;
  logic                            in_valid;
  logic [7:0]                      in_char;
  logic                            in_last;
  su64p_pkg::parse_state_t         state;
  su64p_pkg::parse_state_t         state_next;
  su64p_pkg::result_t              res_next;
  su64p_pkg::result_t              res;
  logic                            out_valid;
  logic                            go;

  assign cfg_ready = 1'b1;
  assign go        = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready  = !in_valid || go;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {res.end_offset, res.value};
  assign m_tuser   = res.status;

  su64p_step u_step (
    .cur   (state),
    .ch    (in_char),
    .last  (in_last),
    .radix (radix),
    .nxt   (state_next),
    .res   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= su64p_pkg::RADIX_RESET;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= su64p_pkg::STATE_CLEAR;
    end else begin
      if (cfg_valid) begin
        radix <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (go) begin
        in_valid <= 1'b0;
      end
      if (go) begin
        state <= state_next;
      end
      if (go && in_last) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
    if (go && in_last) begin
      res <= res_next;
    end
  end

endmodule

[hw/rtl/su64p_checker.sv]
// Port-level checks for string_to_uint64_parser_unit, bound to the top level.
// Depends on su64p_pkg and string_to_uint64_parser_unit_macros.svh.
`include "string_to_uint64_parser_unit_macros.svh"

module su64p_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic        err_word;
  logic        known_status;
  logic        stalled;
  logic [81:0] out_word;

  assign err_word     = m_tvalid && (m_tuser != su64p_pkg::STATUS_OK);
  assign known_status = (m_tuser == su64p_pkg::STATUS_OK) ||
                        (m_tuser == su64p_pkg::STATUS_BAD_BASE) ||
                        (m_tuser == su64p_pkg::STATUS_BAD_PREFIX);
  assign stalled      = m_tvalid && !m_tready;
  assign out_word     = {m_tuser, m_tdata};

  `SU64P_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "result word valid after reset")
  `SU64P_ASSERT(a_err_zero, err_word |-> (m_tdata == '0), "error word carries data")
  `SU64P_ASSERT(a_status_code, m_tvalid |-> known_status, "undefined status code")
  `SU64P_ASSERT(a_out_hold, stalled |=> (m_tvalid && $stable(out_word)), "stalled word changed")

endmodule

bind string_to_uint64_parser_unit su64p_checker u_su64p_checker (.*);
